/* rtl/core/rtsc_pkg.sv */
package rtsc_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int DATA_W          = 16;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 3;

    // pressure divider widths: |(z2 - z1 - 2) * x| < 2^33, z1 + 2 < 2^17
    localparam int NUM_W = 33;
    localparam int DEN_W = 17;

    // pressure constants: p = (2500 - t) * 1000 / (2500 - 900) = (2500 - t) * 5 / 8
    localparam int PRESS_BASE  = 2500;
    localparam int PRESS_MUL   = 5;
    localparam int PRESS_SHIFT = 3;
    localparam int PRESS_MAX   = 16'hffff;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_X_SPAN = 3'd0,
        REG_INV_Y_SPAN = 3'd1,
        REG_X_SCALE    = 3'd2,
        REG_X_FROM_Y   = 3'd3,
        REG_X_OFFSET   = 3'd4,
        REG_Y_FROM_X   = 3'd5,
        REG_Y_SCALE    = 3'd6,
        REG_Y_OFFSET   = 3'd7
    } t_reg_idx;

    typedef enum logic {
        K_PEN_UP = 1'b0,
        K_CALC   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] inv_x;
        logic [DATA_W-1:0] inv_y;
        logic [CFG_W-1:0]  xs;
        logic [CFG_W-1:0]  xm;
        logic [CFG_W-1:0]  xo;
        logic [CFG_W-1:0]  ym;
        logic [CFG_W-1:0]  ys;
        logic [CFG_W-1:0]  yo;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z1;
        logic [DATA_W-1:0] z2;
    } t_item;

    // travels alongside the pressure divider
    typedef struct packed {
        t_kind             kind;
        logic              neg;
        logic [DATA_W-1:0] cx;
        logic [DATA_W-1:0] cy;
    } t_side;

    // queue control from the front
    typedef struct packed {
        logic full;
        logic push;
    } t_qctl;

endpackage

/* rtl/core/resistive_touch_sample_calibrate.sv */
// resistive touch sample calibrate
// input channel (i_in_valid / o_in_ready) takes one averaged sample per
// transfer: pen-up, data-ready, raw x, y, z1, z2. output channel
// (o_out_valid / i_out_ready) gives touch state, calibrated x/y and pressure.
// pen-up samples give a release result with zero fields. pen-down samples
// with no data or zero z1 are dropped at the front; samples with negative
// pressure are dropped at the end of the pipe.
// throughput: one sample per cycle unless the receiver stalls. a sample
// passes through the queue, four operand/multiply/sum stages, the 33-stage
// pressure divider (one quotient bit a stage) and then the output register.
// a two-entry queue decouples the front from the back pipe; when the receiver
// stalls the back pipe holds and the queue fills, then o_in_ready drops.
// the config port writes a register each cycle i_cfg_we is high; write only
// while no sample is in flight.
// reset (synchronous, active low) empties the queue and pipe and restores
// the register defaults.
module resistive_touch_sample_calibrate #(
    parameter int SAMPLE_BITS = rtsc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rtsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rtsc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_pen_up,
    input  logic                           i_data_ready,
    input  logic [rtsc_pkg::DATA_W-1:0]    i_raw_x,
    input  logic [rtsc_pkg::DATA_W-1:0]    i_raw_y,
    input  logic [rtsc_pkg::DATA_W-1:0]    i_raw_z1,
    input  logic [rtsc_pkg::DATA_W-1:0]    i_raw_z2,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_touch_active,
    output logic                           o_position_valid,
    output logic [rtsc_pkg::DATA_W-1:0]    o_coord_x,
    output logic [rtsc_pkg::DATA_W-1:0]    o_coord_y,
    output logic [rtsc_pkg::DATA_W-1:0]    o_pressure
);

    rtsc_pkg::t_cfg  r_cfg;
    rtsc_pkg::t_qctl w_qctl;
    rtsc_pkg::t_item w_fitem;
    rtsc_pkg::t_item w_qitem;
    logic            w_qfull;
    logic            w_qvalid;
    logic            w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_x <= '0;
            r_cfg.inv_y <= '0;
            r_cfg.xs    <= rtsc_pkg::CFG_W'(17388);
            r_cfg.xm    <= -rtsc_pkg::CFG_W'(76);
            r_cfg.xo    <= -rtsc_pkg::CFG_W'(871728);
            r_cfg.ym    <= rtsc_pkg::CFG_W'(119);
            r_cfg.ys    <= rtsc_pkg::CFG_W'(25403);
            r_cfg.yo    <= rtsc_pkg::CFG_W'(45240);
        end else if (i_cfg_we) begin
            case (rtsc_pkg::t_reg_idx'(i_cfg_idx))
                rtsc_pkg::REG_INV_X_SPAN: begin
                    r_cfg.inv_x <= i_cfg_data[rtsc_pkg::DATA_W-1:0];
                end
                rtsc_pkg::REG_INV_Y_SPAN: begin
                    r_cfg.inv_y <= i_cfg_data[rtsc_pkg::DATA_W-1:0];
                end
                rtsc_pkg::REG_X_SCALE:  r_cfg.xs <= i_cfg_data;
                rtsc_pkg::REG_X_FROM_Y: r_cfg.xm <= i_cfg_data;
                rtsc_pkg::REG_X_OFFSET: r_cfg.xo <= i_cfg_data;
                rtsc_pkg::REG_Y_FROM_X: r_cfg.ym <= i_cfg_data;
                rtsc_pkg::REG_Y_SCALE:  r_cfg.ys <= i_cfg_data;
                rtsc_pkg::REG_Y_OFFSET: r_cfg.yo <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    rtsc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pen_up     (i_pen_up),
        .i_data_ready (i_data_ready),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .i_raw_z1     (i_raw_z1),
        .i_raw_z2     (i_raw_z2),
        .i_cfg        (r_cfg),
        .i_q_full     (w_qfull),
        .o_qctl       (w_qctl),
        .o_item       (w_fitem)
    );

    // queue between front and back
    rtsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_full  (w_qfull),
        .o_valid (w_qvalid),
        .o_item  (w_qitem)
    );

    // back: calibration, pressure, output register
    rtsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (w_qvalid),
        .i_q_item         (w_qitem),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_touch_active   (o_touch_active),
        .o_position_valid (o_position_valid),
        .o_coord_x        (o_coord_x),
        .o_coord_y        (o_coord_y),
        .o_pressure       (o_pressure)
    );

endmodule

/* rtl/core/rtsc_fifo.sv */
module rtsc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtsc_pkg::t_qctl      i_ctl,
    input  rtsc_pkg::t_item      i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output rtsc_pkg::t_item      o_item
);

    rtsc_pkg::t_item                r_mem [rtsc_pkg::Q_DEPTH];
    logic [rtsc_pkg::Q_PTR_W-1:0]   r_wr;
    logic [rtsc_pkg::Q_PTR_W-1:0]   r_rd;
    logic [rtsc_pkg::Q_CNT_W-1:0]   r_cnt;
    logic                           w_push;
    logic                           w_pop;

    assign w_push  = i_ctl.push;
    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_full  = (r_cnt == rtsc_pkg::Q_CNT_W'(rtsc_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/rtsc_front.sv */
module rtsc_front #(
    parameter int SAMPLE_BITS = rtsc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_pen_up,
    input  logic                       i_data_ready,
    input  logic [rtsc_pkg::DATA_W-1:0] i_raw_x,
    input  logic [rtsc_pkg::DATA_W-1:0] i_raw_y,
    input  logic [rtsc_pkg::DATA_W-1:0] i_raw_z1,
    input  logic [rtsc_pkg::DATA_W-1:0] i_raw_z2,
    input  rtsc_pkg::t_cfg             i_cfg,
    input  logic                       i_q_full,
    output rtsc_pkg::t_qctl            o_qctl,
    output rtsc_pkg::t_item            o_item
);

    localparam logic [rtsc_pkg::DATA_W-1:0] MASK =
        rtsc_pkg::DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [rtsc_pkg::DATA_W-1:0] w_z1;
    logic                        w_accept;
    logic                        w_drop;

    // optional inversion against a span, clamped at zero
    function automatic logic [rtsc_pkg::DATA_W-1:0] prep_axis(
        input logic [rtsc_pkg::DATA_W-1:0] raw,
        input logic [rtsc_pkg::DATA_W-1:0] span
    );
        logic [rtsc_pkg::DATA_W-1:0] v;
        logic [rtsc_pkg::DATA_W:0]   diff;
        v    = raw & MASK;
        diff = {1'b0, span} - {1'b0, v};
        if (span != '0) begin
            v = diff[rtsc_pkg::DATA_W] ? '0 : diff[rtsc_pkg::DATA_W-1:0];
        end
        return v;
    endfunction

    assign w_z1       = i_raw_z1 & MASK;
    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // pen-down samples without data or with zero z1 give nothing
    assign w_drop = !i_pen_up && (!i_data_ready || (w_z1 == '0));

    assign o_qctl.full = i_q_full;
    assign o_qctl.push = w_accept && !w_drop;

    // classify and prepare the axes
    always_comb begin
        o_item.kind = i_pen_up ? rtsc_pkg::K_PEN_UP : rtsc_pkg::K_CALC;
        o_item.x    = prep_axis(i_raw_x, i_cfg.inv_x);
        o_item.y    = prep_axis(i_raw_y, i_cfg.inv_y);
        o_item.z1   = w_z1;
        o_item.z2   = i_raw_z2 & MASK;
    end

endmodule

/* rtl/core/rtsc_div.sv */
module rtsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [rtsc_pkg::NUM_W-1:0]  i_num,
    input  logic [rtsc_pkg::DEN_W-1:0]  i_den,
    input  rtsc_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [rtsc_pkg::NUM_W-1:0]  o_quo,
    output rtsc_pkg::t_side             o_side
);

    localparam int N     = rtsc_pkg::NUM_W;
    localparam int REM_W = rtsc_pkg::DEN_W + 1;

    logic                           r_v   [N];
    logic [REM_W-1:0]               r_rem [N];
    logic [N-1:0]                   r_nq  [N];
    logic [rtsc_pkg::DEN_W-1:0]     r_den [N];
    rtsc_pkg::t_side                r_s   [N];

    // one quotient bit per stage, numerator bits shift out as quotient bits shift in
    for (genvar k = 0; k < N; k++) begin : g_st
        logic                       w_v;
        logic [REM_W-1:0]           w_rem;
        logic [N-1:0]               w_nq;
        logic [rtsc_pkg::DEN_W-1:0] w_den;
        rtsc_pkg::t_side            w_s;
        logic [REM_W-1:0]           w_trial;
        logic                       w_bit;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = '0;
            assign w_nq  = i_num;
            assign w_den = i_den;
            assign w_s   = i_side;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_nq  = r_nq[k-1];
            assign w_den = r_den[k-1];
            assign w_s   = r_s[k-1];
        end

        assign w_trial = {w_rem[REM_W-2:0], w_nq[N-1]};
        assign w_bit   = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= w_bit ? (w_trial - {1'b0, w_den}) : w_trial;
                r_nq[k]  <= {w_nq[N-2:0], w_bit};
                r_den[k] <= w_den;
                r_s[k]   <= w_s;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_nq[N-1];
    assign o_side  = r_s[N-1];

endmodule

/* rtl/core/rtsc_back.sv */
module rtsc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rtsc_pkg::t_cfg              i_cfg,
    input  logic                        i_q_valid,
    input  rtsc_pkg::t_item             i_q_item,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_touch_active,
    output logic                        o_position_valid,
    output logic [rtsc_pkg::DATA_W-1:0] o_coord_x,
    output logic [rtsc_pkg::DATA_W-1:0] o_coord_y,
    output logic [rtsc_pkg::DATA_W-1:0] o_pressure
);

    localparam int DW  = rtsc_pkg::DATA_W;
    localparam int NW  = rtsc_pkg::NUM_W;
    localparam int PW  = 49;   // 17 x 32 product
    localparam int SW  = 51;   // sum of three
    localparam int TW  = NW + 1;
    localparam int AW  = NW + 2;
    localparam int A5W = AW + 3;

    logic w_adv;

    // stage 0
    logic                      r0_v;
    rtsc_pkg::t_kind           r0_kind;
    logic [DW-1:0]             r0_x;
    logic [DW-1:0]             r0_y;
    logic signed [DW+1:0]      r0_d;
    logic [rtsc_pkg::DEN_W-1:0] r0_den;
    // stage 1
    logic                      r1_v;
    rtsc_pkg::t_kind           r1_kind;
    logic signed [AW-1:0]      r1_prod;
    logic [rtsc_pkg::DEN_W-1:0] r1_den;
    logic signed [PW-1:0]      r1_pxx, r1_pxy, r1_pyy, r1_pyx;
    // stage 2
    logic                      r2_v;
    rtsc_pkg::t_kind           r2_kind;
    logic                      r2_neg;
    logic [NW-1:0]             r2_mag;
    logic [rtsc_pkg::DEN_W-1:0] r2_den;
    logic signed [SW-1:0]      r2_sx, r2_sy;
    // stage 3
    logic                      r3_v;
    logic [NW-1:0]             r3_mag;
    logic [rtsc_pkg::DEN_W-1:0] r3_den;
    rtsc_pkg::t_side           r3_side;
    // divider output
    logic                      w_dv;
    logic [NW-1:0]             w_quo;
    rtsc_pkg::t_side           w_ds;
    // final stage
    logic signed [TW-1:0]      w_t;
    logic signed [AW-1:0]      w_a;
    logic signed [A5W-1:0]     w_a5;
    logic [A5W-1:0]            w_p8;
    logic                      w_drop;
    logic [DW-1:0]             w_press;
    // output register
    logic                      r_out_valid;
    logic                      r_touch;
    logic                      r_pos;
    logic [DW-1:0]             r_cx, r_cy, r_press;

    // truncating divide by 65536 and saturate to signed 16 bits
    function automatic logic [DW-1:0] cal_finish(input logic signed [SW-1:0] s);
        logic signed [SW-1:0]      b;
        logic signed [SW-DW-1:0]   q;
        b = s + (s[SW-1] ? SW'(65535) : SW'(0));
        q = (SW-DW)'(b >>> DW);
        if (q > (SW-DW)'(32767)) begin
            return 16'h7fff;
        end else if (q < -(SW-DW)'(32768)) begin
            return 16'h8000;
        end
        return q[DW-1:0];
    endfunction

    // the whole pipe moves while the output slot can take a result
    assign w_adv = !r_out_valid || i_out_ready;
    assign o_pop = w_adv;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r0_v <= i_q_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // operand prep, products, sums, calibrated coordinates
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_kind <= i_q_item.kind;
            r0_x    <= i_q_item.x;
            r0_y    <= i_q_item.y;
            r0_d    <= $signed({2'b00, i_q_item.z2}) - $signed({2'b00, i_q_item.z1})
                       - (DW+2)'(2);
            r0_den  <= {1'b0, i_q_item.z1} + rtsc_pkg::DEN_W'(2);

            r1_kind <= r0_kind;
            r1_prod <= r0_d * $signed({1'b0, r0_x});
            r1_den  <= r0_den;
            r1_pxx  <= $signed({1'b0, r0_x}) * $signed(i_cfg.xs);
            r1_pxy  <= $signed({1'b0, r0_y}) * $signed(i_cfg.xm);
            r1_pyy  <= $signed({1'b0, r0_y}) * $signed(i_cfg.ys);
            r1_pyx  <= $signed({1'b0, r0_x}) * $signed(i_cfg.ym);

            r2_kind <= r1_kind;
            r2_neg  <= r1_prod[AW-1];
            r2_mag  <= r1_prod[AW-1] ? NW'(-r1_prod) : NW'(r1_prod);
            r2_den  <= r1_den;
            r2_sx   <= r1_pxx + r1_pxy + $signed(i_cfg.xo);
            r2_sy   <= r1_pyy + r1_pyx + $signed(i_cfg.yo);

            r3_mag       <= r2_mag;
            r3_den       <= r2_den;
            r3_side.kind <= r2_kind;
            r3_side.neg  <= r2_neg;
            r3_side.cx   <= cal_finish(r2_sx);
            r3_side.cy   <= cal_finish(r2_sy);
        end
    end

    rtsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r3_v),
        .i_num   (r3_mag),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_ds)
    );

    // pressure from the signed quotient
    always_comb begin
        w_t  = w_ds.neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        w_a  = AW'(rtsc_pkg::PRESS_BASE) - AW'(w_t);
        w_a5 = (A5W'(w_a) <<< 2) + A5W'(w_a);
        w_p8 = A5W'(w_a5 >>> rtsc_pkg::PRESS_SHIFT);
        // negative pressure drops the sample; a of -1 truncates to zero
        w_drop = (w_ds.kind == rtsc_pkg::K_CALC) && w_a[AW-1] && (w_a != -AW'(1));
        if (w_a[AW-1]) begin
            w_press = '0;
        end else if (w_p8 > A5W'(rtsc_pkg::PRESS_MAX)) begin
            w_press = DW'(rtsc_pkg::PRESS_MAX);
        end else begin
            w_press = w_p8[DW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_dv && !w_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_ds.kind == rtsc_pkg::K_CALC) begin
                r_touch <= 1'b1;
                r_pos   <= 1'b1;
                r_cx    <= w_ds.cx;
                r_cy    <= w_ds.cy;
                r_press <= w_press;
            end else begin
                r_touch <= 1'b0;
                r_pos   <= 1'b0;
                r_cx    <= '0;
                r_cy    <= '0;
                r_press <= '0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_touch_active   = r_touch;
    assign o_position_valid = r_pos;
    assign o_coord_x        = r_cx;
    assign o_coord_y        = r_cy;
    assign o_pressure       = r_press;

endmodule

/* rtl/core/rtsc_checker.sv */
module rtsc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [rtsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [rtsc_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_pen_up,
    input logic                           i_data_ready,
    input logic [rtsc_pkg::DATA_W-1:0]    i_raw_x,
    input logic [rtsc_pkg::DATA_W-1:0]    i_raw_y,
    input logic [rtsc_pkg::DATA_W-1:0]    i_raw_z1,
    input logic [rtsc_pkg::DATA_W-1:0]    i_raw_z2,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_touch_active,
    input logic                           o_position_valid,
    input logic [rtsc_pkg::DATA_W-1:0]    o_coord_x,
    input logic [rtsc_pkg::DATA_W-1:0]    o_coord_y,
    input logic [rtsc_pkg::DATA_W-1:0]    o_pressure
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_coord_x)
        && $stable(o_coord_y) && $stable(o_pressure) && $stable(o_touch_active))
        else $error("stalled result changed");

    // release results carry no position
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_touch_active |-> !o_position_valid && o_coord_x == '0
        && o_coord_y == '0 && o_pressure == '0)
        else $error("release result carries data");

    // a touch result always reports a position
    a_touch_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_touch_active == o_position_valid)
        else $error("touch and position flags disagree");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind resistive_touch_sample_calibrate rtsc_checker u_rtsc_checker (.*);
